// File: rtl/kdlp_pkg.sv
package kdlp_pkg;

  // Width of one matrix snapshot and of the configuration masks.
  localparam int unsigned INPUT_BITS = 24;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = INPUT_BITS;

  // Event codes.
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG    = 2'd2;
  localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RELOAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK   = 3'd5;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]      RST_LONG_THRESHOLD = 8'd100;
  localparam logic [CNT_W-1:0]      RST_REPEAT_LIMIT   = 8'd150;
  localparam logic [CNT_W-1:0]      RST_REPEAT_RELOAD  = 8'd140;
  localparam logic [INPUT_BITS-1:0] RST_LONG_MASK      = 24'h5E88A6;
  localparam logic [INPUT_BITS-1:0] RST_REPEAT_MASK    = 24'h060000;
  localparam logic [INPUT_BITS-1:0] RST_PRESENT_MASK   = 24'h7FFFF6;

  // A sampled key. An absent key always carries position zero so that
  // two "no key" values compare equal.
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] pos;
  } key_t;

  typedef struct packed {
    logic [CNT_W-1:0]      long_threshold;
    logic [CNT_W-1:0]      repeat_limit;
    logic [CNT_W-1:0]      repeat_reload;
    logic [INPUT_BITS-1:0] long_key_mask;
    logic [INPUT_BITS-1:0] repeat_key_mask;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
  } event_t;

endpackage

// File: rtl/kdlp_encoder.sv
module kdlp_encoder
  import kdlp_pkg::*;
#(
  parameter int unsigned SCAN_BITS = 24
) (
  input  logic [INPUT_BITS-1:0] levels_i,
  input  logic [INPUT_BITS-1:0] present_mask_i,
  output key_t                  key_o
);

  logic             found;
  logic [POS_W-1:0] first_low;

  // Lowest-numbered low bit wins; scanning downward lets it overwrite.
  always_comb begin
    found     = 1'b0;
    first_low = '0;
    for (int p = SCAN_BITS - 1; p >= 0; p--) begin
      if (!levels_i[p]) begin
        found     = 1'b1;
        first_low = POS_W'(p);
      end
    end
  end

  // An absent position hides any key behind it.
  always_comb begin
    key_o.vld = found && present_mask_i[first_low];
    key_o.pos = key_o.vld ? first_low : '0;
  end

endmodule

// File: rtl/kdlp_fsm.sv
module kdlp_fsm
  import kdlp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  key_t   key_i,
  input  logic   tx_i,
  input  cfg_t   cfg_i,
  output event_t event_o
);

  key_t             last_q, last_d;
  key_t             held_q, held_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sub_q, sub_d;

  logic [CNT_W-1:0] cnt_inc;
  key_t             held_eff;

  always_comb begin
    last_d   = key_i;
    held_d   = held_q;
    cnt_d    = cnt_q;
    sub_d    = sub_q;
    event_o  = '0;
    held_eff = key_i.vld && !held_q.vld ? key_i : held_q;
    cnt_inc  = cnt_q + CNT_W'(1);

    if (last_q == key_i) begin
      if (!key_i.vld) begin
        if (!held_q.vld) begin
          cnt_d = '0;
        end else if (!sub_q || tx_i) begin
          event_o = '{vld: 1'b1, pos: held_q.pos, kind: EV_RELEASE};
          cnt_d   = '0;
          held_d  = '0;
        end else begin
          held_d = '0;
          sub_d  = 1'b0;
        end
      end else if (!held_q.vld && tx_i) begin
        event_o = '{vld: 1'b1, pos: key_i.pos, kind: EV_PRESS};
        held_d  = key_i;
        cnt_d   = CNT_W'(1);
      end else if (held_eff == key_i) begin
        // A fresh press starts at one and is counted up in the same tick.
        held_d = key_i;
        if (!held_q.vld) begin
          cnt_inc = CNT_W'(2);
        end
        cnt_d = cnt_inc;
        if (cnt_inc == cfg_i.long_threshold && cfg_i.long_key_mask[key_i.pos]) begin
          sub_d   = 1'b1;
          event_o = '{vld: 1'b1, pos: key_i.pos, kind: EV_LONG};
        end else if (cnt_inc >= cfg_i.repeat_limit) begin
          cnt_d = cfg_i.repeat_reload;
          if (cfg_i.repeat_key_mask[key_i.pos]) begin
            sub_d   = 1'b1;
            event_o = '{vld: 1'b1, pos: key_i.pos, kind: EV_REPEAT};
          end
        end
      end else begin
        // Another key took over from the held one.
        cnt_d  = '0;
        held_d = '0;
        if (!sub_q || tx_i) begin
          event_o = '{vld: 1'b1, pos: held_q.pos, kind: EV_RELEASE};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      held_q <= '0;
      cnt_q  <= '0;
      sub_q  <= 1'b0;
    end else if (step_i) begin
      last_q <= last_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      sub_q  <= sub_d;
    end
  end

endmodule

// File: rtl/keypad_debounce_long_press.sv
// Keypad scanner with two-sample debounce, long press and autorepeat.
//
// Input channel: one transaction per scan tick carries the active-low matrix
// snapshot (bit row * COLUMNS + column) and the transmit-active flag.
// Output channel: a transaction carries a key position and an event kind
// (release click, press click, long, repeat); a tick gives at most one.
// The configuration port is a plain write port, to be used while idle.
//
// A tick is taken into an input register, then encoded and applied to the
// hold state, and its event (if any) lands in the result register, which
// drives output valid. One tick per cycle is accepted while the result
// register is free or being taken; the encode and counter update are
// combinational.
//
// Reset clears the hold state to "no key" and loads the default thresholds
// and masks. When the receiver stalls, the result register holds its event
// and the input register still takes one more tick; after that, input ready
// drops until the result is taken.
module keypad_debounce_long_press
  import kdlp_pkg::*;
#(
  parameter int unsigned ROWS    = 6,
  parameter int unsigned COLUMNS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INPUT_BITS-1:0] matrix_levels_i,
  input  logic                  tx_active_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      key_position_o,
  output logic [KIND_W-1:0]     event_kind_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Positions past the input word read as low but are never present, so
  // they can only ever give "no key"; the scan stops at POSITIONS or the input width, whichever is smaller.
  localparam int unsigned POSITIONS = ROWS * COLUMNS;
  localparam int unsigned SCAN_BITS = (POSITIONS < INPUT_BITS) ? POSITIONS : INPUT_BITS;

  // Configuration registers.
  cfg_t                  cfg_q;
  logic [INPUT_BITS-1:0] present_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_threshold  <= RST_LONG_THRESHOLD;
      cfg_q.repeat_limit    <= RST_REPEAT_LIMIT;
      cfg_q.repeat_reload   <= RST_REPEAT_RELOAD;
      cfg_q.long_key_mask   <= RST_LONG_MASK;
      cfg_q.repeat_key_mask <= RST_REPEAT_MASK;
      present_mask_q        <= RST_PRESENT_MASK;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LONG_THRESHOLD: cfg_q.long_threshold  <= cfg_wdata_i[CNT_W-1:0];
        CFG_REPEAT_LIMIT:   cfg_q.repeat_limit    <= cfg_wdata_i[CNT_W-1:0];
        CFG_REPEAT_RELOAD:  cfg_q.repeat_reload   <= cfg_wdata_i[CNT_W-1:0];
        CFG_LONG_MASK:      cfg_q.long_key_mask   <= cfg_wdata_i;
        CFG_REPEAT_MASK:    cfg_q.repeat_key_mask <= cfg_wdata_i;
        CFG_PRESENT_MASK:   present_mask_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register. The tick in it is processed whenever the result
  // register is free or being emptied in the same cycle.
  logic                  in_valid_q;
  logic [INPUT_BITS-1:0] levels_q;
  logic                  tx_q;
  logic                  step;
  event_t                ev;
  event_t                res_q, res_d;

  assign step       = in_valid_q && (!res_q.vld || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      levels_q <= matrix_levels_i;
      tx_q     <= tx_active_i;
    end
  end

  key_t key;

  kdlp_encoder #(
    .SCAN_BITS(SCAN_BITS)
  ) u_encoder (
    .levels_i       (levels_q),
    .present_mask_i (present_mask_q),
    .key_o          (key)
  );

  kdlp_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .key_i   (key),
    .tx_i    (tx_q),
    .cfg_i   (cfg_q),
    .event_o (ev)
  );

  // Result register: a processed tick replaces the result (possibly with
  // nothing); otherwise a taken result is cleared.
  always_comb begin
    res_d = res_q;
    if (step) begin
      res_d = ev;
    end else if (out_ready_i) begin
      res_d.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_q.vld;
  assign key_position_o = res_q.pos;
  assign event_kind_o   = res_q.kind;

endmodule

// File: rtl/kdlp_checker.sv
module kdlp_checker
  import kdlp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [POS_W-1:0]  key_position_o,
  input logic [KIND_W-1:0] event_kind_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_position_o)
      && $stable(event_kind_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a full, stalled output side.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input ready low without output stall");

  // Reported keys are always real matrix positions.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_position_o < POS_W'(INPUT_BITS))
    else $error("key position out of range");

  // Once reset has been seen, the block comes out of it idle and ready.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("activity during reset");

endmodule

bind keypad_debounce_long_press kdlp_checker u_kdlp_checker (.*);

// File: tb/keypad_debounce_long_press_tb.sv
`timescale 1ns / 1ps

module keypad_debounce_long_press_tb;
  import kdlp_pkg::*;

  // The two register indexes past the end of the list. Writes to them must
  // leave every real register untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Position code that stands for "no key" in the hold state.
  localparam logic [POS_W-1:0] NO_KEY = POS_W'(INPUT_BITS);

  // Cycles without any transaction on either channel before the run is
  // declared hung. The longest legal quiet spell is a settling pause before
  // a register write plus a random stall, both far below this.
  localparam int unsigned QUIET_LIMIT = 1000;

  // Percentage of cycles in which each side holds back.
  localparam int unsigned IDLE_PCT = 36;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
  } key_event_t;

  // Register settings the random part walks through, in order.
  typedef enum int {
    PH_DEFAULT,
    PH_SHORT_RANDOM,
    PH_LOW_EXTREME,
    PH_ZERO_LIMITS,
    PH_HIGH_EXTREME,
    PH_NO_KEYS,
    PH_WIDE_RANDOM,
    PH_BURST,
    PH_COUNT
  } phase_e;

  // Keeps its own copy of the keypad hold state and registers, predicts the
  // event of every accepted scan tick and checks results in order.
  class keypad_scoreboard;
    logic [CNT_W-1:0]      long_thr;
    logic [CNT_W-1:0]      rep_limit;
    logic [CNT_W-1:0]      rep_reload;
    logic [INPUT_BITS-1:0] long_mask;
    logic [INPUT_BITS-1:0] repeat_mask;
    logic [INPUT_BITS-1:0] present_mask;

    logic [POS_W-1:0] last_key;
    logic [POS_W-1:0] held;
    logic [CNT_W-1:0] count;
    logic             submitted;

    key_event_t  expected_q[$];
    int unsigned errors;
    int unsigned ticks;
    int unsigned kind_count[4];

    function new();
      long_thr     = RST_LONG_THRESHOLD;
      rep_limit    = RST_REPEAT_LIMIT;
      rep_reload   = RST_REPEAT_RELOAD;
      long_mask    = RST_LONG_MASK;
      repeat_mask  = RST_REPEAT_MASK;
      present_mask = RST_PRESENT_MASK;
      last_key     = NO_KEY;
      held         = NO_KEY;
      count        = '0;
      submitted    = 1'b0;
      errors       = 0;
      ticks        = 0;
      kind_count   = '{default: 0};
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LONG_THRESHOLD: long_thr     = data[CNT_W-1:0];
        CFG_REPEAT_LIMIT:   rep_limit    = data[CNT_W-1:0];
        CFG_REPEAT_RELOAD:  rep_reload   = data[CNT_W-1:0];
        CFG_LONG_MASK:      long_mask    = data[INPUT_BITS-1:0];
        CFG_REPEAT_MASK:    repeat_mask  = data[INPUT_BITS-1:0];
        CFG_PRESENT_MASK:   present_mask = data[INPUT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void push_event(logic [POS_W-1:0] pos, logic [KIND_W-1:0] kind);
      key_event_t ev;
      ev.pos  = pos;
      ev.kind = kind;
      expected_q.push_back(ev);
      kind_count[kind]++;
    endfunction

    // One scan tick: encode, debounce, then update the hold state.
    function void note_tick(logic [INPUT_BITS-1:0] levels, logic tx);
      logic [POS_W-1:0] key;
      logic [POS_W-1:0] prev;
      // Walking down from the top leaves the lowest low bit in key. An
      // absent position still wins and reads as no key.
      key = NO_KEY;
      for (int p = INPUT_BITS - 1; p >= 0; p--) begin
        if (!levels[p]) key = present_mask[p] ? POS_W'(p) : NO_KEY;
      end
      ticks++;
      prev     = last_key;
      last_key = key;
      if (prev != key) return;

      if (key == NO_KEY) begin
        if (held == NO_KEY) begin
          count = '0;
          return;
        end
        // After a long or repeat event the release click only shows up
        // while transmitting; otherwise the submitted flag is cleared.
        if (!submitted || tx) begin
          push_event(held, EV_RELEASE);
          count = '0;
          held  = NO_KEY;
          return;
        end
        held      = NO_KEY;
        submitted = 1'b0;
        return;
      end

      if (held == NO_KEY) begin
        held  = key;
        count = 8'd1;
        if (tx) begin
          push_event(held, EV_PRESS);
          return;
        end
      end

      if (held == key) begin
        count = count + 8'd1;
        if (count == long_thr && long_mask[held]) begin
          submitted = 1'b1;
          push_event(held, EV_LONG);
          return;
        end
        if (count >= rep_limit) begin
          count = rep_reload;
          if (repeat_mask[held]) begin
            submitted = 1'b1;
            push_event(held, EV_REPEAT);
          end
        end
        return;
      end

      // A different key took over from the held one.
      if (!submitted || tx) push_event(held, EV_RELEASE);
      count = '0;
      held  = NO_KEY;
    endfunction

    task check_event(logic [POS_W-1:0] pos, logic [KIND_W-1:0] kind);
      key_event_t ev;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event pos %0d kind %0d", pos, kind));
        return;
      end
      ev = expected_q.pop_front();
      if (pos !== ev.pos)
        report_mismatch($sformatf("key_position %0d, expected %0d", pos, ev.pos));
      if (kind !== ev.kind)
        report_mismatch($sformatf("event_kind %0d, expected %0d", kind, ev.kind));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [INPUT_BITS-1:0] matrix_levels_i = '1;
  logic                  tx_active_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [POS_W-1:0]      key_position_o;
  logic [KIND_W-1:0]     event_kind_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  keypad_scoreboard sb = new();

  int unsigned idle_pct      = IDLE_PCT;
  int unsigned quiet_cycles  = 0;
  int unsigned settings_used = 1;
  logic        tx_level      = 1'b0;

  keypad_debounce_long_press u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .matrix_levels_i(matrix_levels_i),
    .tx_active_i    (tx_active_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_position_o (key_position_o),
    .event_kind_o   (event_kind_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side. Everything here is sampled right at the rising edge, so it
  // sees the values from before the edge; ready is redrawn every cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_event(key_position_o, event_kind_o);
    end
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // The watchdog restarts on every transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d events outstanding",
               $realtime, quiet_cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one scan tick, after a random gap, and holds it until accepted.
  // Valid is only lowered inside the gap, so back-to-back ticks keep it high.
  task automatic send_tick(input logic [INPUT_BITS-1:0] levels, input logic tx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    matrix_levels_i <= levels;
    tx_active_i     <= tx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(levels, tx);
  endtask

  // Random traffic carries a transmit flag that mostly stays put for a while.
  task automatic scan(input logic [INPUT_BITS-1:0] levels);
    if ($urandom_range(99) < 12) tx_level = ~tx_level;
    send_tick(levels, tx_level);
  endtask

  // Snapshot with pos as the lowest low bit; bits above it are random and
  // so do not change which key is seen.
  function automatic logic [INPUT_BITS-1:0] key_levels(input logic [POS_W-1:0] pos);
    logic [INPUT_BITS-1:0] lv;
    lv      = INPUT_BITS'($urandom) | ((INPUT_BITS'(1) << pos) - INPUT_BITS'(1));
    lv[pos] = 1'b0;
    return lv;
  endfunction

  // Half the time prefer a present key that can give long or repeat events,
  // since those need long holds to show anything.
  function automatic logic [POS_W-1:0] pick_key();
    logic [POS_W-1:0] pos;
    pos = POS_W'($urandom_range(INPUT_BITS - 1));
    if ($urandom_range(1) == 0) return pos;
    for (int i = 0; i < 8; i++) begin
      if (sb.present_mask[pos] && (sb.long_mask[pos] || sb.repeat_mask[pos])) return pos;
      pos = POS_W'($urandom_range(INPUT_BITS - 1));
    end
    return pos;
  endfunction

  // Registers may only change while the block is idle: every expected event
  // has arrived and a tick with no event has had time to drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Writes all six registers plus both unused indexes. The byte-wide ones
  // get random upper bits, which the block must drop.
  task automatic write_settings(input logic [CNT_W-1:0] thr, input logic [CNT_W-1:0] lim,
                                input logic [CNT_W-1:0] rel,
                                input logic [INPUT_BITS-1:0] lmask,
                                input logic [INPUT_BITS-1:0] rmask,
                                input logic [INPUT_BITS-1:0] pmask);
    logic [CFG_IDX_W-1:0]  idx[8];
    logic [CFG_DATA_W-1:0] val[8];
    idx = '{CFG_LONG_THRESHOLD, CFG_REPEAT_LIMIT, CFG_REPEAT_RELOAD, CFG_LONG_MASK,
            CFG_REPEAT_MASK, CFG_PRESENT_MASK, CFG_SPARE_LO, CFG_SPARE_HI};
    for (int i = 0; i < 8; i++) val[i] = CFG_DATA_W'($urandom);
    val[0][CNT_W-1:0] = thr;
    val[1][CNT_W-1:0] = lim;
    val[2][CNT_W-1:0] = rel;
    val[3] = lmask;
    val[4] = rmask;
    val[5] = pmask;
    settle();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Random part of one setting: mostly clean holds of one key followed by a
  // release or a straight change of key, with bounces and pure noise mixed in.
  // The first hold of each phase runs the full length to reach the counters'
  // thresholds and wrap.
  task automatic run_phase(input int unsigned target, input int unsigned max_hold);
    int unsigned      start;
    int unsigned      len;
    logic [POS_W-1:0] key;
    bit               first;
    start = sb.ticks;
    first = 1'b1;
    while (sb.ticks - start < target) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 3)) send_tick(INPUT_BITS'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(99) < 10) scan(key_levels(pick_key()));
        key   = pick_key();
        len   = first ? max_hold : $urandom_range(1, max_hold);
        first = 1'b0;
        repeat (len) scan(key_levels(key));
        if ($urandom_range(99) < 70) begin
          repeat ($urandom_range(1, 4)) scan('1);
        end
      end
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned max_hold;
    int unsigned rand_lim;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset settings. Positions 0, 3 and 23 are
    // absent there, so they exercise the "absent bit wins" path.
    send_tick('1, 1'b0);
    send_tick('1, 1'b0);
    send_tick('0, 1'b1);                 // every key low, lowest is absent
    send_tick(24'hFFFFFC, 1'b0);         // absent bit 0 hides present bit 1
    send_tick(24'hFFFFFD, 1'b1);         // key 1 while transmitting
    send_tick(24'hFFFFFD, 1'b1);         // debounced: press click
    send_tick(24'hFFFFFD, 1'b1);
    send_tick('1, 1'b1);
    send_tick('1, 1'b1);                 // release click
    send_tick(24'h7FFFFF, 1'b0);         // top position, absent
    send_tick(24'h7FFFFF, 1'b0);
    send_tick(24'hBFFFFF, 1'b0);         // highest present key
    send_tick(24'hBFFFFF, 1'b0);
    send_tick(24'hFFFFDF, 1'b0);         // another key takes over
    send_tick(24'hFFFFDF, 1'b0);         // release click for the old key
    send_tick('1, 1'b0);
    send_tick('1, 1'b0);
    send_tick(24'hFFFFEF, 1'b1);         // contact bounce between two keys
    send_tick(24'hFFFFBF, 1'b1);
    send_tick(24'hFFFFEF, 1'b0);
    send_tick(24'hFFFFBF, 1'b0);
    send_tick('1, 1'b0);
    send_tick('1, 1'b0);

    for (int ph = 0; ph < PH_COUNT; ph++) begin
      case (phase_e'(ph))
        PH_DEFAULT: begin
          // Reset thresholds: long at 100, repeat at 150 for two keys.
          target   = 240;
          max_hold = 170;
        end
        PH_SHORT_RANDOM: begin
          rand_lim = $urandom_range(3, 24);
          write_settings(CNT_W'($urandom_range(2, 12)), CNT_W'(rand_lim),
                         CNT_W'($urandom_range(0, rand_lim)), INPUT_BITS'($urandom),
                         INPUT_BITS'($urandom), INPUT_BITS'($urandom | $urandom));
          target   = 240;
          max_hold = 30;
        end
        PH_LOW_EXTREME: begin
          // A limit of one reloads and repeats on every held tick that gives no long event.
          write_settings(8'd1, 8'd1, 8'd0, '1, '1, '1);
          target   = 200;
          max_hold = 8;
        end
        PH_ZERO_LIMITS: begin
          // Zero threshold and limit are taken as they are; a reload of 255
          // wraps the count to zero and can then match the threshold.
          write_settings(8'd0, 8'd0, ($urandom_range(1) != 0) ? 8'd255 : CNT_W'($urandom),
                         INPUT_BITS'($urandom), INPUT_BITS'($urandom), '1);
          target   = 200;
          max_hold = 12;
        end
        PH_HIGH_EXTREME: begin
          // Everything at the top: the counter wraps past 255 on long holds.
          write_settings('1, '1, '1, '1, '1, '1);
          target   = 400;
          max_hold = 300;
        end
        PH_NO_KEYS: begin
          write_settings(CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom), '0, '0, '0);
          target   = 120;
          max_hold = 10;
        end
        PH_WIDE_RANDOM: begin
          write_settings(CNT_W'($urandom_range(1, 60)), CNT_W'($urandom_range(1, 80)),
                         CNT_W'($urandom), INPUT_BITS'($urandom), INPUT_BITS'($urandom),
                         INPUT_BITS'($urandom | $urandom));
          target   = 280;
          max_hold = 90;
        end
        default: begin
          // Same kind of traffic as the short random phase, but neither side
          // ever holds back.
          rand_lim = $urandom_range(3, 24);
          write_settings(CNT_W'($urandom_range(2, 12)), CNT_W'(rand_lim),
                         CNT_W'($urandom_range(0, rand_lim)), INPUT_BITS'($urandom),
                         INPUT_BITS'($urandom), INPUT_BITS'($urandom | $urandom));
          idle_pct = 0;
          target   = 240;
          max_hold = 30;
        end
      endcase
      run_phase(target, max_hold);
      idle_pct = IDLE_PCT;
    end

    // Drain: every expected event must arrive, and a stray extra event is then
    // given the chance to show up.
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d events never arrived",
                                                         sb.pending()));
    $display("Run covered %0d scan ticks under %0d register settings.",
             sb.ticks, settings_used);
    $display("Events seen: %0d release, %0d press, %0d long, %0d repeat; %0d mismatches.",
             sb.kind_count[EV_RELEASE], sb.kind_count[EV_PRESS], sb.kind_count[EV_LONG],
             sb.kind_count[EV_REPEAT], sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/kdlp_pkg.sv
rtl/kdlp_encoder.sv
rtl/kdlp_fsm.sv
rtl/keypad_debounce_long_press.sv
rtl/kdlp_checker.sv
tb/keypad_debounce_long_press_tb.sv
